### hdl/slu_pkg.sv
// Shared types and constants for the string literal unescaper.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package slu_pkg;

  localparam int CharW = 21;
  localparam int CpW   = 32;
  localparam int KindW = 2;
  localparam int MaxRes = 3;

  // result kinds, carried on tuser
  localparam logic [KindW-1:0] KIND_CHAR = 2'd0;
  localparam logic [KindW-1:0] KIND_OK   = 2'd1;
  localparam logic [KindW-1:0] KIND_BAD  = 2'd2;

  // character codes
  localparam logic [CharW-1:0] CH_QUOTE = 21'h22;
  localparam logic [CharW-1:0] CH_BSL   = 21'h5C;
  localparam logic [CharW-1:0] CH_CR    = 21'h0D;
  localparam logic [CharW-1:0] CH_LF    = 21'h0A;
  localparam logic [CharW-1:0] CH_0     = 21'h30;
  localparam logic [CharW-1:0] CH_7     = 21'h37;
  localparam logic [CharW-1:0] CH_9     = 21'h39;
  localparam logic [CharW-1:0] CH_UA    = 21'h41;
  localparam logic [CharW-1:0] CH_UF    = 21'h46;
  localparam logic [CharW-1:0] CH_LA    = 21'h61;
  localparam logic [CharW-1:0] CH_LF_A  = 21'h66;
  localparam logic [CharW-1:0] CH_X     = 21'h78;
  localparam logic [CharW-1:0] CH_UX    = 21'h58;
  localparam logic [CharW-1:0] CH_D     = 21'h64;
  localparam logic [CharW-1:0] CH_UD    = 21'h44;
  localparam logic [CharW-1:0] CH_U     = 21'h75;
  localparam logic [CharW-1:0] CH_UU    = 21'h55;
  localparam logic [CharW-1:0] CH_A     = 21'h61;
  localparam logic [CharW-1:0] CH_B     = 21'h62;
  localparam logic [CharW-1:0] CH_F     = 21'h66;
  localparam logic [CharW-1:0] CH_N     = 21'h6E;
  localparam logic [CharW-1:0] CH_R     = 21'h72;
  localparam logic [CharW-1:0] CH_T     = 21'h74;
  localparam logic [CharW-1:0] CH_V     = 21'h76;

  localparam logic [3:0] FIXED_SHORT = 4'd4;
  localparam logic [3:0] FIXED_LONG  = 4'd8;

  typedef enum logic [7:0] {
    PH_OPEN   = 8'b0000_0001,
    PH_BODY   = 8'b0000_0010,
    PH_ESC    = 8'b0000_0100,
    PH_HEX    = 8'b0000_1000,
    PH_DEC    = 8'b0001_0000,
    PH_OCT    = 8'b0010_0000,
    PH_FIXED  = 8'b0100_0000,
    PH_CLOSED = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic [KindW-1:0] kind;
  } res_t;

  // results caused by one input beat, packed from entry 0 up
  typedef struct packed {
    logic [1:0]       cnt;
    res_t [MaxRes-1:0] ent;
  } grp_t;

endpackage

`default_nettype wire

### hdl/string_literal_unescaper_unit.sv
// Top level of the string literal unescaper: input register, parser and result buffer.
// Depends on slu_pkg, slu_decode and slu_outq.
//
//  channel | dir | tdata                  | tuser     | tlast
//  in_     | in  | [20:0] char_code, pad  | -         | end_of_token
//  out_    | out | [31:0] code_point      | [1:0] kind| run_end
//
// One beat is taken per cycle while each beat yields at most one result and out_tready
// is high; after a beat with several results the next beat waits at the result buffer.
// The first result of a beat passes through the input register, then the result buffer.
// rst_n is synchronous; it returns the parser to waiting for the opening quote
// and empties both registers. Output stalls back up through the buffer into in_tready.
`default_nettype none

module string_literal_unescaper_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [20:0] char_code, [23:21] zero
  input  wire logic        in_tlast,   // end_of_token
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] code_point
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // run_end
);

  logic                        in_v_r, in_v_nxt;
  logic [slu_pkg::CharW-1:0]   in_char_r;
  logic                        in_last_r;
  logic                        take;
  logic                        q_free;
  slu_pkg::grp_t               grp;

  // beats without results move on regardless of the buffer
  assign take      = in_v_r && ((grp.cnt == 2'd0) || q_free);
  assign in_tready = !in_v_r || take;
  assign in_v_nxt  = (in_tvalid && in_tready) || (in_v_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else        in_v_r <= in_v_nxt;
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata[slu_pkg::CharW-1:0];
      in_last_r <= in_tlast;
    end
  end

  slu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_v    (in_v_r),
    .beat_char (in_char_r),
    .beat_last (in_last_r),
    .take      (take),
    .grp       (grp)
  );

  slu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .grp        (grp),
    .free       (q_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_stuck_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !take |=> in_v_r && $stable(in_char_r) && $stable(in_last_r))
    else $error("held input beat changed");

endmodule

`default_nettype wire

### hdl/slu_decode.sv
// Literal parser: phase, accumulator, digit count and fault state plus the per-beat
// decode that yields up to three results. Depends on slu_pkg.
`default_nettype none

module slu_decode (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       beat_v,
  input  wire logic [slu_pkg::CharW-1:0]  beat_char,
  input  wire logic                       beat_last,
  input  wire logic                       take,
  output slu_pkg::grp_t                   grp
);

  slu_pkg::phase_t        ph_r, ph_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [3:0]             pl_r, pl_nxt;
  logic                   flt_r, flt_nxt;

  logic [slu_pkg::CharW-1:0] c;
  logic        hex_ok, dec_ok, oct_ok;
  logic [3:0]  hex_d;
  logic [3:0]  pl_dec;
  logic        body;
  logic        fl_en, ch_en, st_en;
  logic [31:0] fl_val, ch_val;
  logic [1:0]  st_kind;
  slu_pkg::phase_t ph_step;
  logic [31:0] acc_step;
  logic        flt_step;
  logic [1:0]  k;

  assign c = beat_char;

  always_comb begin
    hex_ok = 1'b0;
    hex_d  = c[3:0];
    if (c >= slu_pkg::CH_0 && c <= slu_pkg::CH_9) begin
      hex_ok = 1'b1;
    end else if ((c >= slu_pkg::CH_LA && c <= slu_pkg::CH_LF_A) ||
                 (c >= slu_pkg::CH_UA && c <= slu_pkg::CH_UF)) begin
      hex_ok = 1'b1;
      hex_d  = c[3:0] + 4'd9;
    end
  end

  assign dec_ok = (c >= slu_pkg::CH_0) && (c <= slu_pkg::CH_9);
  assign oct_ok = (c >= slu_pkg::CH_0) && (c <= slu_pkg::CH_7);
  assign pl_dec = (pl_r != 4'd0) ? pl_r - 4'd1 : 4'd0;

  always_comb begin
    ph_step  = ph_r;
    acc_step = acc_r;
    pl_nxt   = pl_r;
    flt_step = flt_r;
    body     = 1'b0;
    fl_en    = 1'b0;
    fl_val   = acc_r;
    ch_en    = 1'b0;
    ch_val   = {{(32-slu_pkg::CharW){1'b0}}, c};
    if (!flt_r) begin
      unique case (ph_r)
        slu_pkg::PH_OPEN: begin
          if (c == slu_pkg::CH_QUOTE) ph_step = slu_pkg::PH_BODY;
          else flt_step = 1'b1;
        end
        slu_pkg::PH_BODY: body = 1'b1;
        slu_pkg::PH_ESC: begin
          acc_step = 32'd0;
          if (c == slu_pkg::CH_X || c == slu_pkg::CH_UX) begin
            ph_step = slu_pkg::PH_HEX;
          end else if (c == slu_pkg::CH_D || c == slu_pkg::CH_UD) begin
            ph_step = slu_pkg::PH_DEC;
          end else if (oct_ok) begin
            ph_step  = slu_pkg::PH_OCT;
            acc_step = {29'd0, c[2:0]};
          end else if (c == slu_pkg::CH_U) begin
            ph_step = slu_pkg::PH_FIXED;
            pl_nxt  = slu_pkg::FIXED_SHORT;
          end else if (c == slu_pkg::CH_UU) begin
            ph_step = slu_pkg::PH_FIXED;
            pl_nxt  = slu_pkg::FIXED_LONG;
          end else begin
            ph_step = slu_pkg::PH_BODY;
            ch_en   = 1'b1;
            case (c)
              slu_pkg::CH_A: ch_val = 32'd7;
              slu_pkg::CH_B: ch_val = 32'd8;
              slu_pkg::CH_F: ch_val = 32'd12;
              slu_pkg::CH_N: ch_val = 32'd10;
              slu_pkg::CH_R: ch_val = 32'd13;
              slu_pkg::CH_T: ch_val = 32'd9;
              slu_pkg::CH_V: ch_val = 32'd11;
              default:       ch_val = {{(32-slu_pkg::CharW){1'b0}}, c};
            endcase
          end
        end
        slu_pkg::PH_HEX: begin
          if (hex_ok) acc_step = {acc_r[27:0], hex_d};
          else begin
            fl_en = 1'b1;
            body  = 1'b1;
          end
        end
        slu_pkg::PH_DEC: begin
          if (dec_ok) begin
            acc_step = {acc_r[28:0], 3'd0} + {acc_r[30:0], 1'b0} + {28'd0, c[3:0]};
          end else begin
            fl_en = 1'b1;
            body  = 1'b1;
          end
        end
        slu_pkg::PH_OCT: begin
          if (oct_ok) acc_step = {acc_r[28:0], c[2:0]};
          else begin
            fl_en = 1'b1;
            body  = 1'b1;
          end
        end
        slu_pkg::PH_FIXED: begin
          if (hex_ok) acc_step = {acc_r[27:0], hex_d};
          pl_nxt = pl_dec;
          if (pl_dec == 4'd0) begin
            fl_en   = 1'b1;
            fl_val  = acc_step;
            ph_step = slu_pkg::PH_BODY;
          end
        end
        slu_pkg::PH_CLOSED: flt_step = 1'b1;
        default:            flt_step = 1'b1;
      endcase
    end

    // body character handling, also after a flushed escape
    if (body) begin
      ph_step = slu_pkg::PH_BODY;
      ch_val  = {{(32-slu_pkg::CharW){1'b0}}, c};
      if (c == slu_pkg::CH_BSL) ph_step = slu_pkg::PH_ESC;
      else if (c == slu_pkg::CH_CR || c == slu_pkg::CH_LF) flt_step = 1'b1;
      else if (c == slu_pkg::CH_QUOTE) ph_step = slu_pkg::PH_CLOSED;
      else ch_en = 1'b1;
    end

    ph_nxt  = ph_step;
    acc_nxt = acc_step;
    flt_nxt = flt_step;
    st_en   = 1'b0;
    st_kind = slu_pkg::KIND_OK;
    if (beat_last) begin
      // pending state at end of token; char slot is always free here
      if (!flt_step) begin
        if (ph_step == slu_pkg::PH_ESC) begin
          ch_en  = 1'b1;
          ch_val = 32'd0;
        end else if (ph_step == slu_pkg::PH_HEX || ph_step == slu_pkg::PH_DEC ||
                     ph_step == slu_pkg::PH_OCT) begin
          ch_en  = 1'b1;
          ch_val = acc_step;
        end else if (ph_step == slu_pkg::PH_FIXED) begin
          flt_step = 1'b1;
        end
      end
      st_en   = 1'b1;
      st_kind = flt_step ? slu_pkg::KIND_BAD : slu_pkg::KIND_OK;
      ph_nxt  = slu_pkg::PH_OPEN;
      acc_nxt = 32'd0;
      pl_nxt  = 4'd0;
      flt_nxt = 1'b0;
    end
  end

  // pack enabled results in order: flushed value, character, status
  always_comb begin
    grp = '0;
    k   = 2'd0;
    if (fl_en && !flt_r) begin
      grp.ent[k] = '{code_point: fl_val, kind: slu_pkg::KIND_CHAR};
      k = k + 2'd1;
    end
    if (ch_en && !flt_r) begin
      grp.ent[k] = '{code_point: ch_val, kind: slu_pkg::KIND_CHAR};
      k = k + 2'd1;
    end
    if (st_en) begin
      grp.ent[k] = '{code_point: 32'd0, kind: st_kind};
      k = k + 2'd1;
    end
    grp.cnt = beat_v ? k : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= slu_pkg::PH_OPEN;
      acc_r <= 32'd0;
      pl_r  <= 4'd0;
      flt_r <= 1'b0;
    end else if (take) begin
      ph_r  <= ph_nxt;
      acc_r <= acc_nxt;
      pl_r  <= pl_nxt;
      flt_r <= flt_nxt;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    take && beat_last |=> ph_r == slu_pkg::PH_OPEN && !flt_r && acc_r == 32'd0)
    else $error("state not cleared after end of token");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    take && flt_r |-> grp.cnt == (beat_last ? 2'd1 : 2'd0))
    else $error("characters emitted after a fault");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && beat_last |-> grp.cnt != 2'd0 && grp.ent[grp.cnt - 2'd1].kind != slu_pkg::KIND_CHAR)
    else $error("end of token without status result");

endmodule

`default_nettype wire

### hdl/slu_outq.sv
// Result buffer: holds the up to three results of one beat and hands them
// out one per cycle while out_tready is high. Depends on slu_pkg.
`default_nettype none

module slu_outq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  slu_pkg::grp_t                    grp,
  output logic                             free,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [slu_pkg::CpW-1:0]          out_tdata,
  output logic [slu_pkg::KindW-1:0]        out_tuser,
  output logic                             out_tlast
);

  slu_pkg::res_t [slu_pkg::MaxRes-1:0] ent_r, ent_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic       pop;

  assign out_tvalid = (rem_r != 2'd0);
  assign out_tdata  = ent_r[0].code_point;
  assign out_tuser  = ent_r[0].kind;
  assign out_tlast  = (rem_r == 2'd1);
  assign pop        = out_tvalid && out_tready;
  // a new group may land as the last held result leaves
  assign free       = (rem_r == 2'd0) || (rem_r == 2'd1 && out_tready);

  always_comb begin
    ent_nxt = ent_r;
    rem_nxt = rem_r;
    // an empty group leaves the held results alone
    if (load && grp.cnt != 2'd0) begin
      ent_nxt = grp.ent;
      rem_nxt = grp.cnt;
    end else if (pop) begin
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      rem_nxt    = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) rem_r <= 2'd0;
    else        rem_r <= rem_nxt;
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load && grp.cnt != 2'd0 |-> free)
    else $error("group loaded over pending results");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && grp.cnt != 2'd0 |=> out_tvalid && rem_r == $past(grp.cnt))
    else $error("loaded group not presented");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> rem_r == $past(rem_r))
    else $error("results lost while stalled");

endmodule

`default_nettype wire
